// File: rtl/udht_pkg.sv
`default_nettype none

package udht_pkg;

    // Command codes carried by each input transaction.
    localparam logic [1:0] CMD_UP      = 2'd0;
    localparam logic [1:0] CMD_DOWN    = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;
    localparam logic [1:0] CMD_INVALID = 2'd3;

    // Digit selector codes.
    localparam logic [2:0] SEL_HOUR     = 3'd1;
    localparam logic [2:0] SEL_MIN_TENS = 3'd2;
    localparam logic [2:0] SEL_MIN_ONES = 3'd3;
    localparam logic [2:0] SEL_SEC_TENS = 3'd4;
    localparam logic [2:0] SEL_SEC_ONES = 3'd5;

    // Highest hour that a tick up may reach before the time wraps to zero.
    localparam logic [4:0] MAX_HOUR_UP = 5'd1;

    localparam logic [5:0] LAST_UNIT = 6'd59;

    // Load split: hours by threshold compare, minutes by reciprocal multiply.
    localparam int HOUR_SECS      = 3600;
    localparam int LOAD_MAX_HOURS = 18;
    // floor(rest * MIN_RECIP / 2^MIN_SHIFT) equals rest / 60 for all rest < 3600.
    localparam int MIN_RECIP = 4370;
    localparam int MIN_SHIFT = 18;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] load_seconds;
        logic [2:0]  digit_select;
    } t_in_item;

    typedef struct packed {
        logic        wrap_flag;
        logic [4:0]  hours_now;
        logic [5:0]  minutes_now;
        logic [5:0]  seconds_now;
        logic [4:0]  selected_digit;
        logic [17:0] time_decimal;
    } t_out_item;

    // Tens digit of a value below 64: (x * 13) >> 7 is exact over that range.
    function automatic logic [3:0] tens_of(input logic [5:0] x);
        logic [10:0] prod;
        prod = 11'(x) * 11'd13;
        return prod[10:7];
    endfunction

    // Ones digit of a value below 64.
    function automatic logic [3:0] ones_of(input logic [5:0] x);
        logic [3:0] t;
        logic [6:0] t10;
        t   = tens_of(x);
        t10 = {t, 3'b000} + 7'({t, 1'b0});
        return 4'(7'(x) - t10);
    endfunction

endpackage

`default_nettype wire

// File: rtl/udht_if.sv
`default_nettype none

// Input channel: valid/ready handshake with one command per transaction.
interface udht_in_if;
    import udht_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel: valid/ready handshake with one time report per transaction.
interface udht_out_if;
    import udht_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/up_down_hms_timer.sv
// Channel   Direction  Transaction carries
// i_req     in         command, load_seconds, digit_select
// o_rsp     out        wrap_flag, hours/minutes/seconds, selected_digit, time_decimal
//
// One transaction per cycle is accepted unless the stages are full and stalled; each
// result is offered once its command has passed the input register, two load-split
// stages, counter update and output register. Only the counter update stage writes the time.
// Reset clears all stage valid bits and sets the time to 0:00:00.
// Each stage holds while the stage after it is full and stalled, so bubbles are
// squeezed out and input keeps flowing while a result waits at the output, until all stages fill.

`default_nettype none

module up_down_hms_timer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    udht_in_if.sink   i_req,
    udht_out_if.source o_rsp
);
    import udht_pkg::*;

    // Stage valid bits and advance enables.
    logic r_s0_valid, r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic adv0, adv1, adv2, adv3, adv4;

    // Stage payloads.
    t_in_item   r_s0;
    logic [1:0]  r_s1_cmd, r_s2_cmd;
    logic [2:0]  r_s1_sel, r_s2_sel, r_s3_sel;
    logic [4:0]  r_s1_hour, r_s2_hour;
    logic [11:0] r_s1_rest, r_s2_rest;
    logic [5:0]  r_s2_min;
    logic        r_s3_flag;
    t_out_item   r_out;

    // Counter state; it doubles as the time payload of stage three.
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_min, n_min;
    logic [5:0] r_sec, n_sec;
    logic       n_flag;

    logic [4:0]  n_ld_hour;
    logic [15:0] ld_base;
    logic [11:0] n_ld_rest;
    logic [23:0] min_prod;
    logic [5:0]  n_ld_min;
    logic [11:0] min_secs;
    logic [5:0]  ld_sec;
    logic [4:0]  n_digit;
    logic [17:0] n_decimal;

    // Ready chain: a stage takes a new transaction when empty or when it moves on.
    assign adv4        = !r_out_valid || o_rsp.ready;
    assign adv3        = !r_s3_valid || adv4;
    assign adv2        = !r_s2_valid || adv3;
    assign adv1        = !r_s1_valid || adv2;
    assign adv0        = !r_s0_valid || adv1;
    assign i_req.ready = adv0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv0) r_s0_valid  <= i_req.valid;
            if (adv1) r_s1_valid  <= r_s0_valid;
            if (adv2) r_s2_valid  <= r_s1_valid;
            if (adv3) r_s3_valid  <= r_s2_valid;
            if (adv4) r_out_valid <= r_s3_valid;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_s0 <= i_req.data;
        end
    end

    // Load split, hours: count the whole hours below the seconds count.
    always_comb begin
        n_ld_hour = '0;
        ld_base   = '0;
        for (int k = 1; k <= LOAD_MAX_HOURS; k++) begin
            if (r_s0.load_seconds >= 16'(k * HOUR_SECS)) begin
                n_ld_hour = 5'(k);
                ld_base   = 16'(k * HOUR_SECS);
            end
        end
        n_ld_rest = 12'(r_s0.load_seconds - ld_base);
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_cmd  <= r_s0.command;
            r_s1_sel  <= r_s0.digit_select;
            r_s1_hour <= n_ld_hour;
            r_s1_rest <= n_ld_rest;
        end
    end

    // Load split, minutes: reciprocal multiply of the remainder.
    assign min_prod = 24'(r_s1_rest) * 24'(MIN_RECIP);
    assign n_ld_min = 6'(min_prod >> MIN_SHIFT);

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_sel  <= r_s1_sel;
            r_s2_hour <= r_s1_hour;
            r_s2_rest <= r_s1_rest;
            r_s2_min  <= n_ld_min;
        end
    end

    // Load split, seconds: remainder minus minutes times sixty.
    assign min_secs = {r_s2_min, 6'b000000} - 12'({r_s2_min, 2'b00});
    assign ld_sec   = 6'(r_s2_rest - min_secs);

    // Counter update: tick up, tick down, load or invalid command.
    always_comb begin
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_flag = 1'b0;
        unique case (r_s2_cmd)
            CMD_UP: begin
                if (r_sec < LAST_UNIT) begin
                    n_sec = r_sec + 6'd1;
                end else if (r_min < LAST_UNIT) begin
                    n_sec = '0;
                    n_min = r_min + 6'd1;
                end else if (r_hour < MAX_HOUR_UP) begin
                    n_sec  = '0;
                    n_min  = '0;
                    n_hour = r_hour + 5'd1;
                end else begin
                    n_sec  = '0;
                    n_min  = '0;
                    n_hour = '0;
                    n_flag = 1'b1;
                end
            end
            CMD_DOWN: begin
                if (r_sec != '0) begin
                    n_sec = r_sec - 6'd1;
                end else if (r_min != '0) begin
                    n_sec = LAST_UNIT;
                    n_min = r_min - 6'd1;
                end else if (r_hour != '0) begin
                    n_sec  = LAST_UNIT;
                    n_min  = LAST_UNIT;
                    n_hour = r_hour - 5'd1;
                end else begin
                    n_flag = 1'b1;
                end
            end
            CMD_LOAD: begin
                n_hour = r_s2_hour;
                n_min  = r_s2_min;
                n_sec  = ld_sec;
            end
            CMD_INVALID: begin
                n_flag = 1'b1;
            end
            default: begin
                n_flag = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour <= '0;
            r_min  <= '0;
            r_sec  <= '0;
        end else if (adv3 && r_s2_valid) begin
            r_hour <= n_hour;
            r_min  <= n_min;
            r_sec  <= n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_flag <= n_flag;
            r_s3_sel  <= r_s2_sel;
        end
    end

    // Display digit and packed decimal from the updated time.
    always_comb begin
        case (r_s3_sel)
            SEL_HOUR:     n_digit = r_hour;
            SEL_MIN_TENS: n_digit = 5'(tens_of(r_min));
            SEL_MIN_ONES: n_digit = 5'(ones_of(r_min));
            SEL_SEC_TENS: n_digit = 5'(tens_of(r_sec));
            SEL_SEC_ONES: n_digit = 5'(ones_of(r_sec));
            default:      n_digit = '0;
        endcase
    end

    assign n_decimal = 18'(r_hour) * 18'd10000 + 18'(r_min) * 18'd100 + 18'(r_sec);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_out.wrap_flag      <= r_s3_flag;
            r_out.hours_now      <= r_hour;
            r_out.minutes_now    <= r_min;
            r_out.seconds_now    <= r_sec;
            r_out.selected_digit <= n_digit;
            r_out.time_decimal   <= n_decimal;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result valid right after reset");

    // Minutes and seconds never leave their range.
    a_units_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min <= LAST_UNIT) && (r_sec <= LAST_UNIT))
        else $error("minute or second counter out of range");

    // A tick down at zero keeps the time at zero and raises the flag.
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv3 && r_s2_valid && r_s2_cmd == CMD_DOWN && r_hour == '0 && r_min == '0
         && r_sec == '0)
        |=> (r_hour == '0 && r_min == '0 && r_sec == '0 && r_s3_flag))
        else $error("underflow did not hold zero");

    // An invalid command leaves the time unchanged.
    a_invalid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv3 && r_s2_valid && r_s2_cmd == CMD_INVALID)
        |=> ($stable(r_hour) && $stable(r_min) && $stable(r_sec) && r_s3_flag))
        else $error("invalid command changed the time");

endmodule

`default_nettype wire
